// ----- rtl/core/psq_pkg.sv -----
package psq_pkg;

    // Sequencer phases, in the encoding that leaves the block on o_phase.
    typedef enum logic [2:0] {
        PH_TS_OFF    = 3'd0,
        PH_WAIT_INV  = 3'd1,
        PH_WAIT_VOLT = 3'd2,
        PH_READY     = 3'd3,
        PH_FAILED    = 3'd4
    } t_phase;

    // Event kinds carried on the input channel.
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_INV1 = 2'd1,
        OP_INV2 = 2'd2,
        OP_PACK = 2'd3
    } t_op;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_LINK_TIMEOUT = 2'd0,
        CFG_INV_WAIT     = 2'd1,
        CFG_VOLT_WAIT    = 2'd2,
        CFG_THRESHOLD    = 2'd3
    } t_cfg_idx;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned LIMIT_W  = 16;
    localparam int unsigned VOLT_W   = 16;
    localparam int unsigned PACK_W   = 13;
    localparam int unsigned THRESH_W = 7;

    localparam logic [LIMIT_W-1:0]  LINK_TIMEOUT_RST = 16'd500;
    localparam logic [LIMIT_W-1:0]  INV_WAIT_RST     = 16'd5000;
    localparam logic [LIMIT_W-1:0]  VOLT_WAIT_RST    = 16'd3743;
    localparam logic [THRESH_W-1:0] THRESHOLD_RST    = 7'd95;

    typedef struct packed {
        logic [LIMIT_W-1:0]  link_timeout_ms;
        logic [LIMIT_W-1:0]  inv_wait_ms;
        logic [LIMIT_W-1:0]  volt_wait_ms;
        logic [THRESH_W-1:0] threshold_pct;
    } t_cfg;

    // Result of one step as seen by the output register.
    typedef struct packed {
        t_phase phase;
        logic   pchg_release;
        logic   break_loop;
        logic   inv1_alive;
        logic   inv2_alive;
    } t_result;

endpackage

// ----- rtl/core/psq_engine.sv -----
module psq_engine
    import psq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  t_op                 i_op,
    input  logic [VOLT_W-1:0]   i_voltage,
    input  logic                i_ts_active,
    input  t_cfg                i_cfg,
    output t_result             o_result
);

    // Reciprocal of ten in 19 fractional bits; exact for every 16 bit value.
    localparam logic [32:0] DIV10_MUL = 33'd52429;

    logic [TIME_W-1:0]  r_now;
    logic [TIME_W-1:0]  r_inv1_last;
    logic [TIME_W-1:0]  r_inv2_last;
    logic [VOLT_W-1:0]  r_inv1_volts;
    logic [VOLT_W-1:0]  r_inv2_volts;
    logic [PACK_W-1:0]  r_pack_volts;
    t_phase             r_state;
    logic [TIME_W-1:0]  r_seq_start;
    logic [1:0]         r_alive;

    logic [TIME_W-1:0]  n_now;
    logic [1:0]         n_alive;
    t_phase             n_state;
    logic [TIME_W-1:0]  n_seq_start;

    logic [VOLT_W-1:0]  w_low_volts;
    logic [22:0]        w_low_scaled;
    logic [22:0]        w_pack_scaled;
    logic [32:0]        w_div_prod;
    logic               w_tick;
    t_phase             w_phase;
    logic [1:0]         w_alive;

    function automatic logic over_limit(
        input logic [TIME_W-1:0]  now,
        input logic [TIME_W-1:0]  mark,
        input logic [LIMIT_W-1:0] limit
    );
        logic [TIME_W-1:0] diff;
        diff = now - mark;
        return diff > {{(TIME_W-LIMIT_W){1'b0}}, limit};
    endfunction

    assign w_tick = i_step && (i_op == OP_TICK);
    assign n_now  = r_now + 32'd1;

    // Link flags as refreshed by a tick against the advanced clock.
    assign n_alive[0] = !over_limit(n_now, r_inv1_last, i_cfg.link_timeout_ms);
    assign n_alive[1] = !over_limit(n_now, r_inv2_last, i_cfg.link_timeout_ms);

    assign w_low_volts   = (r_inv1_volts < r_inv2_volts) ? r_inv1_volts : r_inv2_volts;
    assign w_low_scaled  = 23'(w_low_volts) * 23'd100;
    assign w_pack_scaled = 23'(r_pack_volts) * 23'(i_cfg.threshold_pct);
    assign w_div_prod    = 33'(i_voltage) * DIV10_MUL;

    // Next state of the sequence for a tick.
    always_comb begin
        n_state     = r_state;
        n_seq_start = r_seq_start;
        unique case (r_state)
            PH_TS_OFF: begin
                if (i_ts_active) begin
                    n_state     = PH_WAIT_INV;
                    n_seq_start = n_now;
                end
            end
            PH_WAIT_INV: begin
                if (n_alive == 2'b11) begin
                    n_state = PH_WAIT_VOLT;
                end else if (over_limit(n_now, r_seq_start, i_cfg.inv_wait_ms)) begin
                    n_state = PH_FAILED;
                end
            end
            PH_WAIT_VOLT: begin
                if (w_low_scaled > w_pack_scaled) begin
                    n_state = PH_READY;
                end else if (over_limit(n_now, r_seq_start, i_cfg.volt_wait_ms)) begin
                    n_state = PH_FAILED;
                end
            end
            PH_READY: begin
                n_state = PH_READY;
            end
            default: begin
                n_state = PH_FAILED;
            end
        endcase
    end

    // Outputs follow the phase the step leaves behind.
    always_comb begin
        w_phase = w_tick ? n_state : r_state;
        w_alive = w_tick ? n_alive : r_alive;
        o_result.phase        = w_phase;
        o_result.pchg_release = (w_phase == PH_READY);
        o_result.break_loop   = (w_phase != PH_READY);
        o_result.inv1_alive   = w_alive[0];
        o_result.inv2_alive   = w_alive[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now        <= '0;
            r_inv1_last  <= '0;
            r_inv2_last  <= '0;
            r_inv1_volts <= '0;
            r_inv2_volts <= '0;
            r_pack_volts <= '0;
            r_state      <= PH_TS_OFF;
            r_seq_start  <= '0;
            r_alive      <= 2'b11;
        end else if (i_step) begin
            unique case (i_op)
                OP_TICK: begin
                    r_now       <= n_now;
                    r_alive     <= n_alive;
                    r_state     <= n_state;
                    r_seq_start <= n_seq_start;
                end
                OP_INV1: begin
                    r_inv1_last  <= r_now;
                    r_inv1_volts <= i_voltage;
                end
                OP_INV2: begin
                    r_inv2_last  <= r_now;
                    r_inv2_volts <= i_voltage;
                end
                OP_PACK: begin
                    r_pack_volts <= w_div_prod[31:19];
                end
                default: begin
                    r_now <= r_now;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/precharge_sequencer_with_link_watchdog.sv -----
// Precharge sequencer with inverter link watchdog.
// The input channel (i_in_valid / o_in_stall) carries one event per beat: a
// 1 ms tick, an inverter 1 or inverter 2 frame with its bus voltage, or a pack
// voltage frame in 0.1 V units. Every beat produces exactly one result beat on
// the output channel (o_out_valid / i_out_stall) holding the phase, the
// precharge release, the loop break request and both link alive flags.
// A taken beat lands in the input register, is evaluated by the engine and
// is caught by the result register; a receiver stall can hold it in the input
// register. One beat per cycle is sustained while the receiver does not stall;
// the rate is set by the single update of the sequencer state.
// When the receiver stalls, the result register holds; the input register
// still takes one more beat, and only then is o_in_stall raised.
// The configuration port (i_cfg_valid / o_cfg_ready) is always ready and
// writes the register picked by i_cfg_index; write it only while idle.
// Synchronous reset clears both pipeline registers, restores the register
// defaults (500, 5000, 3743, 95), sets the phase to TS off and marks both
// links alive. No clearing pass is needed after reset.
module precharge_sequencer_with_link_watchdog
    import psq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_op,
    input  logic [VOLT_W-1:0]   i_voltage,
    input  logic                i_ts_active,

    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [2:0]          o_phase,
    output logic                o_pchg_release,
    output logic                o_break_loop,
    output logic                o_inv1_alive,
    output logic                o_inv2_alive,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [LIMIT_W-1:0]  i_cfg_data
);

    // Input register.
    logic               r_in_valid;
    t_op                r_op;
    logic [VOLT_W-1:0]  r_voltage;
    logic               r_ts_active;

    // Result register.
    logic               r_out_valid;
    t_result            r_result;

    t_cfg               r_cfg;
    t_result            w_result;
    logic               w_advance;
    logic               w_in_take;

    // The input register moves on whenever the result register is empty or
    // being drained in this cycle.
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op        <= t_op'(i_op);
            r_voltage   <= i_voltage;
            r_ts_active <= i_ts_active;
        end
    end

    psq_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_op        (r_op),
        .i_voltage   (r_voltage),
        .i_ts_active (r_ts_active),
        .i_cfg       (r_cfg),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_phase        = r_result.phase;
    assign o_pchg_release = r_result.pchg_release;
    assign o_break_loop   = r_result.break_loop;
    assign o_inv1_alive   = r_result.inv1_alive;
    assign o_inv2_alive   = r_result.inv2_alive;

    // Configuration registers; the port never pushes back.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_timeout_ms <= LINK_TIMEOUT_RST;
            r_cfg.inv_wait_ms     <= INV_WAIT_RST;
            r_cfg.volt_wait_ms    <= VOLT_WAIT_RST;
            r_cfg.threshold_pct   <= THRESHOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LINK_TIMEOUT: r_cfg.link_timeout_ms <= i_cfg_data;
                CFG_INV_WAIT:     r_cfg.inv_wait_ms     <= i_cfg_data;
                CFG_VOLT_WAIT:    r_cfg.volt_wait_ms    <= i_cfg_data;
                CFG_THRESHOLD:    r_cfg.threshold_pct   <= i_cfg_data[THRESH_W-1:0];
                default:          r_cfg                 <= r_cfg;
            endcase
        end
    end

endmodule
